[src/als_pkg.sv]
// Shared types and constants for the addressable LED serializer.
// No dependencies; the front end, queue, slot engine and top import this package.
`default_nettype none

package als_pkg;

  // Strip geometry
  localparam int LED_COUNT   = 64;
  localparam int LED_AW      = $clog2(LED_COUNT);      // colour store address
  localparam int LED_PW      = $clog2(LED_COUNT + 1);  // pointer that can reach LED_COUNT
  localparam int BITS_PER_LED = 24;
  localparam int RESET_SLOTS = (LED_COUNT % 2 == 0) ? 48 : 24;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 2;

  // Configuration register indexes
  localparam logic [1:0] CFG_ZERO_DUTY   = 2'd0;
  localparam logic [1:0] CFG_GREEN_SCALE = 2'd1;
  localparam logic [1:0] CFG_BLUE_SCALE  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [6:0] ZERO_DUTY_RST   = 7'd19;
  localparam logic [7:0] GREEN_SCALE_RST = 8'hB0;
  localparam logic [7:0] BLUE_SCALE_RST  = 8'hF0;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_RENDER = 2'd1,
    OP_TICK   = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [6:0] zero_duty;
    logic [7:0] green_scale;
    logic [7:0] blue_scale;
  } cfg_t;

  // Classified command: green and blue are already scaled; colour is in green, red, blue order
  typedef struct packed {
    opcode_e    op;
    logic [5:0] idx;
    logic [23:0] colour;
  } cmd_t;

endpackage

`default_nettype wire

[src/als_if.sv]
// Valid/ready channel interfaces for the LED serializer input and result streams.
// Payload field widths follow the package; depends on als_pkg only by convention.
`default_nettype none

interface als_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [5:0] led_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output opcode, output led_index, output red,
                  output green, output blue, input ready);
  modport sink   (input valid, input opcode, input led_index, input red,
                  input green, input blue, output ready);
endinterface

interface als_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic       sending;
  logic       frame_last;

  modport source (output valid, output duty, output sending, output frame_last,
                  input ready);
  modport sink   (input valid, input duty, input sending, input frame_last,
                  output ready);
endinterface

`default_nettype wire

[src/als_front.sv]
// Front end: accepts input items, drops unused opcodes, scales green and blue.
// Depends on als_pkg and als_in_if.
`default_nettype none

module als_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  als_in_if.sink             in_i,
  input  wire als_pkg::cfg_t cfg_i,
  output      als_pkg::cmd_t cmd_o,
  output      logic          cmd_valid_o,
  input  wire logic          cmd_ready_i
);
  import als_pkg::*;

  logic  valid_q, valid_d;
  cmd_t  cmd_q, cmd_d;
  logic  advance;
  logic  keep;
  logic [15:0] g_prod, b_prod;

  // Stage moves when empty or when the queue takes its content
  assign advance     = !valid_q || cmd_ready_i;
  assign in_i.ready  = advance;
  assign cmd_o       = cmd_q;
  assign cmd_valid_o = valid_q;

  // Scaling products, registered below
  assign g_prod = 16'(in_i.green) * 16'(cfg_i.green_scale);
  assign b_prod = 16'(in_i.blue) * 16'(cfg_i.blue_scale);

  // Classify
  always_comb begin
    case (opcode_e'(in_i.opcode))
      OP_WRITE, OP_RENDER, OP_TICK: keep = 1'b1;
      default:                      keep = 1'b0;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (advance) begin
      valid_d    = in_i.valid && keep;
      cmd_d.op   = opcode_e'(in_i.opcode);
      cmd_d.idx  = in_i.led_index;
      cmd_d.colour = {g_prod[15:8], in_i.red, b_prod[15:8]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

`default_nettype wire

[src/als_cmd_fifo.sv]
// Short command queue between the front end and the slot engine.
// Depends on als_pkg for the command type and depth.
`default_nettype none

module als_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire als_pkg::cmd_t push_cmd_i,
  input  wire logic          push_valid_i,
  output      logic          push_ready_o,
  output      als_pkg::cmd_t pop_cmd_o,
  output      logic          pop_valid_o,
  input  wire logic          pop_ready_i
);
  import als_pkg::*;

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  cmd_t          mem_q [FIFO_DEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = (cnt_q != CW'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

[src/als_back.sv]
// Slot engine: colour store, frame counters and the registered result stage.
// Depends on als_pkg and als_out_if.
`default_nettype none

module als_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire als_pkg::cmd_t cmd_i,
  input  wire logic          cmd_valid_i,
  output      logic          cmd_ready_o,
  input  wire als_pkg::cfg_t cfg_i,
  als_out_if.source          out_o
);
  import als_pkg::*;

  typedef struct packed {
    logic       data;     // data bit slot (else reset slot or idle)
    logic [4:0] bit_sel;  // bit of the colour word, MSB first
    logic       sending;
    logic       last;
  } slot_t;

  // Frame counters
  logic              busy_q, busy_d;
  logic [LED_PW-1:0] led_ptr_q, led_ptr_d;
  logic [4:0]        bit_pos_q, bit_pos_d;
  logic [5:0]        rst_left_q, rst_left_d;
  logic [5:0]        rst_left_dec;

  // Result stage
  logic  out_valid_q, out_valid_d;
  slot_t slot_q, slot_d;
  logic  can_take, pop, is_tick;

  // Colour store
  logic [23:0]    store_q [LED_COUNT];
  logic           vld_q [LED_COUNT];
  logic [23:0]    rdata_q;
  logic           rvld_q;
  logic           wr_en, rd_en;
  logic [LED_AW-1:0] wr_addr, rd_addr;
  logic [23:0]    word;
  logic [4:0]     bit_idx;

  assign can_take    = !out_valid_q || out_o.ready;
  assign is_tick     = (cmd_i.op == OP_TICK);
  assign cmd_ready_o = !is_tick || can_take;
  assign pop         = cmd_valid_i && cmd_ready_o;

  assign wr_en   = pop && (cmd_i.op == OP_WRITE) && (32'(cmd_i.idx) < 32'(LED_COUNT));
  assign wr_addr = LED_AW'(cmd_i.idx);
  assign rd_addr = led_ptr_q[LED_AW-1:0];
  assign rst_left_dec = (rst_left_q != '0) ? rst_left_q - 1'b1 : '0;

  // Counter and slot classification for the head command
  always_comb begin
    busy_d      = busy_q;
    led_ptr_d   = led_ptr_q;
    bit_pos_d   = bit_pos_q;
    rst_left_d  = rst_left_q;
    rd_en       = 1'b0;
    slot_d      = slot_q;
    out_valid_d = out_valid_q;
    if (can_take) begin
      out_valid_d = 1'b0;
    end
    if (pop) begin
      case (cmd_i.op)
        OP_RENDER: begin
          busy_d     = !busy_q;
          rst_left_d = busy_q ? '0 : 6'(RESET_SLOTS);
          led_ptr_d  = '0;
          bit_pos_d  = '0;
        end
        OP_TICK: begin
          out_valid_d    = 1'b1;
          slot_d.data    = 1'b0;
          slot_d.bit_sel = bit_pos_q;
          slot_d.sending = busy_q;
          slot_d.last    = 1'b0;
          if (busy_q) begin
            if (led_ptr_q < LED_PW'(LED_COUNT)) begin
              slot_d.data = 1'b1;
              rd_en       = (bit_pos_q == '0);
              if (bit_pos_q == 5'(BITS_PER_LED - 1)) begin
                bit_pos_d = '0;
                led_ptr_d = led_ptr_q + 1'b1;
              end else begin
                bit_pos_d = bit_pos_q + 1'b1;
              end
            end else begin
              rst_left_d = rst_left_dec;
              if (rst_left_dec == '0) begin
                slot_d.last = 1'b1;
                busy_d      = 1'b0;
                led_ptr_d   = '0;
                bit_pos_d   = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      led_ptr_q   <= '0;
      bit_pos_q   <= '0;
      rst_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      led_ptr_q   <= led_ptr_d;
      bit_pos_q   <= bit_pos_d;
      rst_left_q  <= rst_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  // Store valid bits; an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        vld_q[i] <= 1'b0;
      end
      rvld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= vld_q[rd_addr];
      end
    end
  end

  // Colour store; read data holds as the latched word of the LED in flight
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= cmd_i.colour;
    end
    if (rd_en) begin
      rdata_q <= store_q[rd_addr];
    end
  end

  // Duty from the latched word
  assign word    = rvld_q ? rdata_q : '0;
  assign bit_idx = 5'(BITS_PER_LED - 1) - slot_q.bit_sel;

  always_comb begin
    out_o.duty = '0;
    if (slot_q.data) begin
      out_o.duty = word[bit_idx] ? {cfg_i.zero_duty, 1'b0} : {1'b0, cfg_i.zero_duty};
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sending    = slot_q.sending;
  assign out_o.frame_last = slot_q.last;

  // Checks
  a_last_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && slot_q.last |-> slot_q.sending && !slot_q.data)
    else $error("frame_last outside a frame");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (led_ptr_q <= LED_PW'(LED_COUNT)) && (bit_pos_q < 5'(BITS_PER_LED)))
    else $error("frame counters out of range");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (rst_left_q == '0) && (led_ptr_q == '0) && (bit_pos_q == '0))
    else $error("counters not cleared while idle");

  a_read_on_led_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> busy_q && (bit_pos_q == '0) && is_tick)
    else $error("store read outside the first bit of an LED");

  a_end_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && is_tick && busy_q && (led_ptr_q == LED_PW'(LED_COUNT)) && (rst_left_q <= 6'd1)
    |=> !busy_q)
    else $error("frame did not end after its last reset slot");

endmodule

`default_nettype wire

[src/addressable_led_serializer_top.sv]
// Top level of the addressable LED serializer: configuration registers,
// front end, command queue and slot engine. Depends on als_pkg and als_if.
//
//   channel  dir  handshake    payload
//   in_i     in   valid/ready  opcode, led_index, red, green, blue
//   out_o    out  valid/ready  duty, sending, frame_last (tick items only)
//   cfg      in   cfg_we_i     cfg_idx_i, cfg_wdata_i
//
// One item per cycle sustained while out_o does not stall; a tick's result
// passes the front register, the queue and the result register before it is
// offered. The store read for each LED is issued on its first bit slot from
// the colour store array, which has a separate write port.
// Reset clears the colour store at once through per-LED valid bits.
// Either side may stall independently; the two-entry queue absorbs the gap.
`default_nettype none

module addressable_led_serializer_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  als_in_if.sink          in_i,
  als_out_if.source       out_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i
);
  import als_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ZERO_DUTY:   cfg_d.zero_duty   = cfg_wdata_i[6:0];
        CFG_GREEN_SCALE: cfg_d.green_scale = cfg_wdata_i;
        CFG_BLUE_SCALE:  cfg_d.blue_scale  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_duty   <= ZERO_DUTY_RST;
      cfg_q.green_scale <= GREEN_SCALE_RST;
      cfg_q.blue_scale  <= BLUE_SCALE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  als_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_q),
    .cmd_o       (f_cmd),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready)
  );

  als_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cmd_i   (f_cmd),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_cmd_o    (q_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready)
  );

  als_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cfg_i       (cfg_q),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
